FILE: hw/rtl/phm_pkg.sv
`default_nettype none
package phm_pkg;

  localparam int BIN_COUNT   = 256;
  localparam int LEVEL_W     = 8;
  localparam int MEAN_W      = 16;
  localparam int FRAC_W      = 8;
  localparam int OUT_COUNT_W = 24;

  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_ADD   = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;
  localparam logic [1:0] FUNC_MEAN  = 2'd3;

  localparam logic [2:0] MODE_LUMA   = 3'd0;
  localparam logic [2:0] MODE_INTENS = 3'd1;
  localparam logic [2:0] MODE_VALUE  = 3'd2;
  localparam logic [2:0] MODE_CHROMA = 3'd3;
  localparam logic [2:0] MODE_RED    = 3'd4;
  localparam logic [2:0] MODE_GREEN  = 3'd5;
  localparam logic [2:0] MODE_BLUE   = 3'd6;

  // luminance weights over 2^16, rounding half up
  localparam logic [15:0] LUMA_R    = 16'd13933;
  localparam logic [15:0] LUMA_G    = 16'd46871;
  localparam logic [15:0] LUMA_B    = 16'd4732;
  localparam logic [23:0] LUMA_HALF = 24'd32768;

  // floor(x / 3) == (x * 683) >> 11 for every x up to 765
  localparam logic [9:0] DIV3_MUL   = 10'd683;
  localparam int         DIV3_SHIFT = 11;

  typedef struct packed {
    logic accept;
    logic prod_en;
    logic lvl_en;
    logic clear;
    logic bin_rd;
    logic bin_wr;
    logic idx_rd;
    logic div_start;
    logic load_out;
  } phm_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       total_zero;
    logic       div_done;
  } phm_sts_t;

endpackage
`default_nettype wire

FILE: hw/rtl/phm_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle. The partial remainder
// loaded at start must already be below the divisor.
module phm_div #(
  parameter int DEN_W = 24,
  parameter int Q_W   = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DEN_W-1:0] rem_init,
  input  wire logic [Q_W-1:0]   low_bits,
  input  wire logic [DEN_W-1:0] den,
  output logic      [Q_W-1:0]   quo,
  output logic                  done
);

  localparam int CNT_W = $clog2(Q_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(Q_W - 1);

  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [Q_W-1:0]   shf_r, shf_nxt;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;

  assign trial = {rem_r, shf_r[Q_W-1]};
  assign diff  = trial - {1'b0, den_r};

  always_comb begin
    rem_nxt  = rem_r;
    shf_nxt  = shf_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = rem_init;
      shf_nxt  = low_bits;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // no borrow means the divisor fits: keep the difference
      if (!diff[DEN_W]) begin
        rem_nxt = diff[DEN_W-1:0];
        shf_nxt = {shf_r[Q_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DEN_W-1:0];
        shf_nxt = {shf_r[Q_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    shf_r <= shf_nxt;
    cnt_r <= cnt_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign quo  = shf_r;
  assign done = done_r;

endmodule
`default_nettype wire

FILE: hw/rtl/phm_datapath.sv
`default_nettype none
module phm_datapath #(
  parameter int COUNT_BITS = 24
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire phm_pkg::phm_cmd_t cmd,
  output phm_pkg::phm_sts_t      sts,
  input  wire logic [31:0]       in_tdata,
  input  wire logic [1:0]        in_tuser,
  input  wire logic              cfg_valid,
  input  wire logic [2:0]        cfg_data,
  output logic      [47:0]       out_tdata,
  output logic                   out_tuser
);

  import phm_pkg::*;

  localparam int SUM_W = COUNT_BITS + LEVEL_W;
  localparam int EXT_W = COUNT_BITS + OUT_COUNT_W;

  function automatic logic [7:0] max3(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c);
    logic [7:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic logic [7:0] min3(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c);
    logic [7:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  logic [2:0]            mode_r;
  logic [1:0]            func_r;
  logic [7:0]            red_r, grn_r, blu_r, idx_r;
  logic [23:0]           pr_r, pg_r, pb_r;
  logic [9:0]            sum3_r;
  logic [7:0]            max_r, min_r;
  logic [LEVEL_W-1:0]    level_r, level_nxt;
  logic [LEVEL_W-1:0]    pix_r;
  logic                  empty_r;
  logic [COUNT_BITS-1:0] total_r;
  logic [SUM_W-1:0]      sum_r;
  logic [BIN_COUNT-1:0]  valid_r;
  logic [COUNT_BITS-1:0] mem [BIN_COUNT];
  logic [COUNT_BITS-1:0] rd_q_r;
  logic [LEVEL_W-1:0]    raddr;
  logic [COUNT_BITS-1:0] bin_old, bin_new, idx_cnt;
  logic [EXT_W-1:0]      cnt_ext;
  logic [23:0]           luma_sum;
  logic [19:0]           div3_prod;
  logic [MEAN_W-1:0]     quo;
  logic                  div_done;
  logic [LEVEL_W-1:0]    out_lvl_r;
  logic [OUT_COUNT_W-1:0] out_cnt_r;
  logic [MEAN_W-1:0]     out_mean_r;
  logic                  out_empty_r;

  // level select from the registered products
  assign luma_sum  = pr_r + pg_r + pb_r + LUMA_HALF;
  assign div3_prod = 20'(sum3_r) * 20'(DIV3_MUL);

  always_comb begin
    unique case (mode_r)
      MODE_LUMA:   level_nxt = luma_sum[23:16];
      MODE_INTENS: level_nxt = 8'(div3_prod >> DIV3_SHIFT);
      MODE_VALUE:  level_nxt = max_r;
      MODE_CHROMA: level_nxt = max_r - min_r;
      MODE_RED:    level_nxt = red_r;
      MODE_GREEN:  level_nxt = grn_r;
      MODE_BLUE:   level_nxt = blu_r;
      default:     level_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_r <= in_tuser;
      red_r  <= in_tdata[7:0];
      grn_r  <= in_tdata[15:8];
      blu_r  <= in_tdata[23:16];
      idx_r  <= in_tdata[31:24];
      pix_r  <= '0;
      empty_r <= (in_tuser == FUNC_MEAN) && (total_r == '0);
    end else if (cmd.lvl_en) begin
      pix_r <= level_nxt;
    end
    if (cmd.prod_en) begin
      pr_r   <= 24'(red_r) * 24'(LUMA_R);
      pg_r   <= 24'(grn_r) * 24'(LUMA_G);
      pb_r   <= 24'(blu_r) * 24'(LUMA_B);
      sum3_r <= 10'(red_r) + 10'(grn_r) + 10'(blu_r);
      max_r  <= max3(red_r, grn_r, blu_r);
      min_r  <= min3(red_r, grn_r, blu_r);
    end
    if (cmd.lvl_en) begin
      level_r <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_LUMA;
    end else if (cfg_valid) begin
      mode_r <= cfg_data;
    end
  end

  // bin memory: a cleared bin is marked invalid and reads as zero
  assign raddr   = cmd.idx_rd ? idx_r : level_r;
  assign bin_old = valid_r[level_r] ? rd_q_r : '0;
  assign bin_new = (&bin_old) ? bin_old : bin_old + COUNT_BITS'(1);

  always_ff @(posedge clk) begin
    if (cmd.bin_wr) begin
      mem[level_r] <= bin_new;
    end
    if (cmd.bin_rd || cmd.idx_rd) begin
      rd_q_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      valid_r <= '0;
      total_r <= '0;
      sum_r   <= '0;
    end else if (cmd.bin_wr) begin
      valid_r[level_r] <= 1'b1;
      // hold both totals once the pixel count is full
      if (!(&total_r)) begin
        total_r <= total_r + COUNT_BITS'(1);
        sum_r   <= sum_r + SUM_W'(level_r);
      end
    end
  end

  phm_div #(
    .DEN_W (COUNT_BITS),
    .Q_W   (MEAN_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .rem_init (sum_r[SUM_W-1:LEVEL_W]),
    .low_bits ({sum_r[LEVEL_W-1:0], {FRAC_W{1'b0}}}),
    .den      (total_r),
    .quo      (quo),
    .done     (div_done)
  );

  assign idx_cnt = valid_r[idx_r] ? rd_q_r : '0;
  assign cnt_ext = EXT_W'(idx_cnt);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_lvl_r   <= pix_r;
      out_cnt_r   <= cnt_ext[OUT_COUNT_W-1:0];
      out_mean_r  <= (func_r == FUNC_MEAN && !empty_r) ? quo : '0;
      out_empty_r <= empty_r;
    end
  end

  assign out_tdata = {out_mean_r, out_cnt_r, out_lvl_r};
  assign out_tuser = out_empty_r;

  assign sts.func       = func_r;
  assign sts.total_zero = (total_r == '0);
  assign sts.div_done   = div_done;

endmodule
`default_nettype wire

FILE: hw/rtl/phm_ctrl.sv
`default_nettype none
module phm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  input  wire phm_pkg::phm_sts_t sts,
  output phm_pkg::phm_cmd_t      cmd
);

  import phm_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PROD = 3'd1;
  localparam logic [2:0] S_LVL  = 3'd2;
  localparam logic [2:0] S_RDB  = 3'd3;
  localparam logic [2:0] S_WRB  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_RDI  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_PROD;
        end
      end
      S_PROD: begin
        unique case (sts.func)
          FUNC_ADD: begin
            cmd.prod_en = 1'b1;
            state_nxt   = S_LVL;
          end
          FUNC_CLEAR: begin
            cmd.clear = 1'b1;
            state_nxt = S_RDI;
          end
          FUNC_MEAN: begin
            if (sts.total_zero) begin
              state_nxt = S_RDI;
            end else begin
              cmd.div_start = 1'b1;
              state_nxt     = S_DIV;
            end
          end
          default: state_nxt = S_RDI;
        endcase
      end
      S_LVL: begin
        cmd.lvl_en = 1'b1;
        state_nxt  = S_RDB;
      end
      S_RDB: begin
        cmd.bin_rd = 1'b1;
        state_nxt  = S_WRB;
      end
      S_WRB: begin
        cmd.bin_wr = 1'b1;
        state_nxt  = S_RDI;
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_RDI;
        end
      end
      S_RDI: begin
        cmd.idx_rd = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        // wait for the output register to drain
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

endmodule
`default_nettype wire

FILE: hw/rtl/pixel_histogram_with_mean.sv
// Add pixel steps through the product, level, bin read, bin write, index
// bin read and output states; clear, read bin and a mean of an empty
// histogram skip to the index bin read, and a mean first runs the 16-step
// restoring divider. One item at a time: the next item is taken the cycle
// after the result is registered, which waits while the output is stalled.
// Reset (rst_n low, synchronous) empties all bins and totals and sets mode 0.
`default_nettype none
module pixel_histogram_with_mean #(
  parameter int COUNT_BITS = 24
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // red, green, blue, bin_index
  input  wire logic [1:0]  in_tuser,   // func
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [47:0] out_tdata,  // pixel_level, bin_count, mean_level
  output logic             out_tuser,  // empty_flag
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_data    // level_mode
);

  import phm_pkg::*;

  phm_cmd_t cmd;
  phm_sts_t sts;

  assign cfg_ready = 1'b1;

  phm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  phm_datapath #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule
`default_nettype wire

FILE: hw/rtl/phm_checker.sv
`default_nettype none
module phm_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [47:0] out_tdata,
  input wire logic        out_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // one item in flight: no accept right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item accepted while previous item busy");

  // an empty mean carries a zero mean and no pixel level
  a_empty_mean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[47:32] == 16'd0 && out_tdata[7:0] == 8'd0)
    else $error("empty result with nonzero mean or level");

  // reset drops the result
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind pixel_histogram_with_mean phm_checker u_chk (.*);
`default_nettype wire

FILE: tb/sv/pixel_histogram_with_mean_tb.sv
module pixel_histogram_with_mean_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import phm_pkg::*;

  localparam logic [2:0]  MODE_UNUSED = 3'd7;
  localparam logic [31:0] W_RED       = 32'd13933;
  localparam logic [31:0] W_GREEN     = 32'd46871;
  localparam logic [31:0] W_BLUE      = 32'd4732;
  localparam logic [31:0] W_HALF      = 32'd32768;
  localparam logic [23:0] COUNT_TOP   = 24'hFF_FFFF;
  localparam int          NUM_DIRECTED = 26;
  localparam int          NUM_BLOCKS   = 17;
  localparam int          BLOCK_ITEMS  = 100;

  typedef struct packed {
    logic [7:0]  pixel_level;
    logic [23:0] bin_count;
    logic [15:0] mean_level;
    logic        empty_flag;
  } hist_res_t;

  typedef enum logic {ROW_ITEM, ROW_MODE} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [2:0]  mode;
    logic [1:0]  func;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  bin_index;
    logic        typed;
    hist_res_t   res;
  } dir_row_t;

  // kind, mode, func, red, green, blue, bin_index, typed, {level, count, mean, empty}
  localparam dir_row_t DIR_TAB [NUM_DIRECTED] = '{
    '{ROW_ITEM, MODE_LUMA, FUNC_MEAN, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1,
      '{8'd0, 24'd0, 16'd0, 1'b1}},
    '{ROW_ITEM, MODE_LUMA, FUNC_READ, 8'd0, 8'd0, 8'd0, 8'd255, 1'b1,
      '{8'd0, 24'd0, 16'd0, 1'b0}},
    '{ROW_ITEM, MODE_LUMA, FUNC_ADD, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1,
      '{8'd255, 24'd1, 16'd0, 1'b0}},
    '{ROW_ITEM, MODE_LUMA, FUNC_ADD, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1,
      '{8'd0, 24'd1, 16'd0, 1'b0}},
    '{ROW_ITEM, MODE_LUMA, FUNC_MEAN, 8'd0, 8'd0, 8'd0, 8'd255, 1'b0, '0},
    '{ROW_MODE, MODE_INTENS, FUNC_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, '0},
    '{ROW_ITEM, MODE_INTENS, FUNC_ADD, 8'd255, 8'd0, 8'd0, 8'd85, 1'b0, '0},
    '{ROW_MODE, MODE_VALUE, FUNC_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, '0},
    '{ROW_ITEM, MODE_VALUE, FUNC_ADD, 8'd10, 8'd200, 8'd30, 8'd200, 1'b0, '0},
    '{ROW_MODE, MODE_CHROMA, FUNC_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, '0},
    '{ROW_ITEM, MODE_CHROMA, FUNC_ADD, 8'd10, 8'd200, 8'd30, 8'd190, 1'b0, '0},
    '{ROW_MODE, MODE_RED, FUNC_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, '0},
    '{ROW_ITEM, MODE_RED, FUNC_ADD, 8'hA5, 8'h5A, 8'h0F, 8'hA5, 1'b0, '0},
    '{ROW_MODE, MODE_GREEN, FUNC_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, '0},
    '{ROW_ITEM, MODE_GREEN, FUNC_ADD, 8'hA5, 8'h5A, 8'h0F, 8'h5A, 1'b0, '0},
    '{ROW_MODE, MODE_BLUE, FUNC_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, '0},
    '{ROW_ITEM, MODE_BLUE, FUNC_ADD, 8'hA5, 8'h5A, 8'h0F, 8'h0F, 1'b0, '0},
    '{ROW_MODE, MODE_UNUSED, FUNC_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, '0},
    '{ROW_ITEM, MODE_UNUSED, FUNC_ADD, 8'd255, 8'd255, 8'd255, 8'd0, 1'b0, '0},
    '{ROW_ITEM, MODE_UNUSED, FUNC_MEAN, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, '0},
    '{ROW_ITEM, MODE_UNUSED, FUNC_CLEAR, 8'd0, 8'd0, 8'd0, 8'd255, 1'b1,
      '{8'd0, 24'd0, 16'd0, 1'b0}},
    '{ROW_ITEM, MODE_UNUSED, FUNC_MEAN, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1,
      '{8'd0, 24'd0, 16'd0, 1'b1}},
    '{ROW_MODE, MODE_LUMA, FUNC_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, '0},
    '{ROW_ITEM, MODE_LUMA, FUNC_ADD, 8'd128, 8'd64, 8'd32, 8'hAA, 1'b0, '0},
    '{ROW_ITEM, MODE_LUMA, FUNC_READ, 8'd255, 8'd255, 8'd255, 8'd0, 1'b0, '0},
    '{ROW_ITEM, MODE_LUMA, FUNC_MEAN, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, '0}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // red, green, blue, bin_index
  logic [1:0]  in_tuser = '0;   // func
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;       // pixel_level, bin_count, mean_level
  logic        out_tuser;       // empty_flag
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_data = '0;   // level_mode

  // predictor state
  logic [23:0] hist_bins [BIN_COUNT];
  logic [31:0] hist_level_sum;
  logic [23:0] hist_pixel_total;
  logic [2:0]  hist_mode;

  hist_res_t   pending_results [$];
  int          hist_errors = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  logic [7:0]  last_level = '0;

  pixel_histogram_with_mean dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [7:0] level_of_pixel(input logic [2:0] m, input logic [7:0] r,
                                                input logic [7:0] g, input logic [7:0] b);
    logic [31:0] acc;
    logic [9:0]  sum;
    logic [7:0]  hi;
    logic [7:0]  lo;
    acc = W_RED * r + W_GREEN * g + W_BLUE * b + W_HALF;
    sum = 10'(r) + 10'(g) + 10'(b);
    hi  = (r > g) ? r : g;
    hi  = (hi > b) ? hi : b;
    lo  = (r < g) ? r : g;
    lo  = (lo < b) ? lo : b;
    case (m)
      MODE_LUMA:   return acc[23:16];
      MODE_INTENS: return 8'(sum / 10'd3);
      MODE_VALUE:  return hi;
      MODE_CHROMA: return hi - lo;
      MODE_RED:    return r;
      MODE_GREEN:  return g;
      MODE_BLUE:   return b;
      default:     return 8'd0;
    endcase
  endfunction

  task automatic predict_histogram_step(input logic [1:0] f, input logic [7:0] r,
                                        input logic [7:0] g, input logic [7:0] b,
                                        input logic [7:0] idx, output hist_res_t res);
    logic [7:0]  lvl;
    logic [39:0] quot;
    res = '0;
    case (f)
      FUNC_CLEAR: begin
        for (int i = 0; i < BIN_COUNT; i++) hist_bins[i] = '0;
        hist_level_sum   = '0;
        hist_pixel_total = '0;
      end
      FUNC_ADD: begin
        lvl = level_of_pixel(hist_mode, r, g, b);
        if (hist_bins[lvl] != COUNT_TOP) hist_bins[lvl] = hist_bins[lvl] + 24'd1;
        // totals freeze once the pixel count is full
        if (hist_pixel_total != COUNT_TOP) begin
          hist_pixel_total = hist_pixel_total + 24'd1;
          hist_level_sum   = hist_level_sum + 32'(lvl);
        end
        res.pixel_level = lvl;
      end
      FUNC_MEAN: begin
        if (hist_pixel_total == '0) begin
          res.empty_flag = 1'b1;
        end else begin
          quot = {hist_level_sum, 8'd0} / {16'd0, hist_pixel_total};
          res.mean_level = quot[15:0];
        end
      end
      default: ;
    endcase
    res.bin_count = hist_bins[idx];
  endtask

  task automatic push_pixel_item(input logic [1:0] f, input logic [7:0] r,
                                 input logic [7:0] g, input logic [7:0] b,
                                 input logic [7:0] idx, input logic typed,
                                 input hist_res_t typed_res);
    hist_res_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= {idx, b, g, r};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_histogram_step(f, r, g, b, idx, pred);
    pending_results.push_back(typed ? typed_res : pred);
    if (f == FUNC_ADD) last_level = pred.pixel_level;
  endtask

  task automatic write_level_mode(input logic [2:0] m);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    hist_mode = m;
  endtask

  function automatic logic [7:0] rand_channel();
    case ($urandom_range(9))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // result checker and receiver stalls
  initial begin
    hist_res_t want;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          $error("result item with nothing expected: %h / %b", out_tdata, out_tuser);
          hist_errors++;
        end else begin
          want = pending_results.pop_front();
          if (out_tdata[7:0] !== want.pixel_level) begin
            $error("pixel_level: expected %0d, got %0d", want.pixel_level, out_tdata[7:0]);
            hist_errors++;
          end
          if (out_tdata[31:8] !== want.bin_count) begin
            $error("bin_count: expected %0d, got %0d", want.bin_count, out_tdata[31:8]);
            hist_errors++;
          end
          if (out_tdata[47:32] !== want.mean_level) begin
            $error("mean_level: expected %0d, got %0d", want.mean_level, out_tdata[47:32]);
            hist_errors++;
          end
          if (out_tuser !== want.empty_flag) begin
            $error("empty_flag: expected %0d, got %0d", want.empty_flag, out_tuser);
            hist_errors++;
          end
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    #10ms;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [1:0] f;
    logic [7:0] idx;
    int         pick;
    for (int i = 0; i < BIN_COUNT; i++) hist_bins[i] = '0;
    hist_level_sum   = '0;
    hist_pixel_total = '0;
    hist_mode        = MODE_LUMA;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int n = 0; n < NUM_DIRECTED; n++) begin
      if (DIR_TAB[n].kind == ROW_MODE) begin
        write_level_mode(DIR_TAB[n].mode);
      end else begin
        push_pixel_item(DIR_TAB[n].func, DIR_TAB[n].red, DIR_TAB[n].green, DIR_TAB[n].blue,
                        DIR_TAB[n].bin_index, DIR_TAB[n].typed, DIR_TAB[n].res);
      end
    end

    for (int blk = 0; blk < NUM_BLOCKS; blk++) begin
      case (blk / 6)
        0: begin
          send_idle_pct  = 26;
          recv_stall_pct = 68;
        end
        1: begin
          send_idle_pct  = 68;
          recv_stall_pct = 26;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      // walk every mode once, then pick at random
      write_level_mode(blk < 8 ? 3'(blk) : 3'($urandom_range(7)));
      for (int k = 0; k < BLOCK_ITEMS; k++) begin
        pick = $urandom_range(99);
        if (pick < 4)       f = FUNC_CLEAR;
        else if (pick < 74) f = FUNC_ADD;
        else if (pick < 88) f = FUNC_READ;
        else                f = FUNC_MEAN;
        idx = $urandom_range(1) ? last_level : 8'($urandom_range(255));
        push_pixel_item(f, rand_channel(), rand_channel(), rand_channel(), idx, 1'b0, '0);
      end
    end

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (hist_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
